>>> rtl/core/ffba_pkg.sv
`default_nettype none
package ffba_pkg;
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned CFG_AW = 4;

  typedef enum logic [1:0] {
    MARK_FREE   = 2'd0,
    MARK_START  = 2'd1,
    MARK_MIDDLE = 2'd2,
    MARK_END    = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_BLOCK_SHIFT   = 4'h0,
    REG_USABLE_BLOCKS = 4'h4,
    REG_REGION_BASE   = 4'h8
  } reg_addr_t;

  localparam int unsigned OP_ALLOC = 0;

  // request as it leaves the front end
  typedef struct packed {
    logic        op_free;
    logic        bad;       // zero/oversize alloc or out-of-map free
    logic [16:0] req;       // blocks needed, alloc
    logic [16:0] first;     // first candidate (alloc) or block id (free)
    logic [4:0]  step_log2; // candidate stride as a shift
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MARK,
    BK_FCHK,
    BK_FWALK,
    BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

>>> rtl/core/ffba_ram.sv
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/ffba_front.sv
`default_nettype none
module ffba_front
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op_free,
  input  wire logic [31:0] request_bytes,
  input  wire logic [4:0]  align_log2,
  input  wire logic [31:0] release_address,
  input  wire logic [4:0]  block_shift,
  input  wire logic [16:0] limit_n,
  input  wire logic [31:0] region_base,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);
  // two-entry queue
  cmd_t        q_r [2];
  logic [1:0]  cnt_r;
  logic        rd_r;
  logic        wr_r;
  cmd_t        c;
  logic [31:0] mask;
  logic [31:0] ceil_blk;
  logic [31:0] amask;
  logic [31:0] off;
  logic [31:0] rel;
  logic [31:0] id;
  logic        push;
  logic        pop;

  always_comb begin
    mask     = ~(32'hFFFF_FFFF << block_shift);
    ceil_blk = (request_bytes >> block_shift) + {31'd0, |(request_bytes & mask)};
    amask    = ~(32'hFFFF_FFFF << align_log2);
    off      = ((32'd0 - region_base) & amask) >> block_shift;
    rel      = release_address - region_base;
    id       = rel >> block_shift;
    c        = '0;
    c.op_free = op_free;
    if (op_free) begin
      c.bad   = (id >= MAX_BLOCKS);
      c.first = id[16:0];
    end else begin
      c.bad = (request_bytes == 32'd0) || (ceil_blk > {15'd0, limit_n});
      c.req = ceil_blk[16:0];
      if (align_log2 > block_shift) begin
        c.first     = (off > 32'h1FFFF) ? 17'h1FFFF : off[16:0];
        c.step_log2 = align_log2 - block_shift;
      end
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      q_r[wr_r] <= c;
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

>>> rtl/core/ffba_back.sv
`default_nettype none
module ffba_back
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  input  wire logic [4:0]  block_shift,
  input  wire logic [16:0] limit_n,
  input  wire logic [31:0] region_base,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      granted_address,
  output logic [10:0]      free_count,
  output logic [10:0]      used_count,
  output logic             busy
);
  localparam int unsigned AW = $clog2(MAX_BLOCKS);

  bk_state_t   st_r, st_nxt;
  cmd_t        c_r;
  logic [16:0] base_r, base_nxt;   // candidate start
  logic [16:0] pos_r, pos_nxt;     // probe / mark / walk position
  logic [16:0] tot_r, tot_nxt;     // allocated total (wider than needed for clears)
  logic        clr_r, clr_nxt;     // clearing pass
  logic [1:0]  res_st_r, res_st_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic        ov_r, ov_nxt;
  logic        rvld_r, rvld_nxt;   // ram read for pos issued last cycle
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]  wdata, rdata;
  logic [16:0] cand_end;
  logic [16:0] nxt_base;
  logic [17:0] kk;
  logic [16:0] stepm;
  logic [16:0] pos_adv;
  logic [16:0] free_w;

  ffba_ram #(.WIDTH(2), .DEPTH(MAX_BLOCKS)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    stepm    = ~(17'h1FFFF << c_r.step_log2);
    cand_end = base_r + c_r.req;
    // next aligned candidate past blocked position pos_r
    kk       = {1'b0, pos_r} + 18'd1 - {1'b0, c_r.first} + {1'b0, stepm};
    nxt_base = c_r.first + ((kk[16:0] >> c_r.step_log2) << c_r.step_log2);
    if (kk[17]) begin
      nxt_base = 17'h1FFFF;
    end
    pos_adv  = pos_r + 17'd1;
  end

  // next state
  always_comb begin
    st_nxt       = st_r;
    base_nxt     = base_r;
    pos_nxt      = pos_r;
    tot_nxt      = tot_r;
    clr_nxt      = clr_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    ov_nxt       = ov_r;
    rvld_nxt     = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (clr_r) begin
          pos_nxt = pos_adv;
          if (pos_r == 17'(MAX_BLOCKS - 1)) begin
            clr_nxt = 1'b0;
          end
        end else if (cmd_valid) begin
          res_addr_nxt = 32'd0;
          if (cmd.bad) begin
            res_st_nxt = cmd.op_free ? ST_BADFREE : ST_NOFIT;
            st_nxt     = BK_DONE;
          end else if (cmd.op_free) begin
            pos_nxt  = cmd.first;
            rvld_nxt = 1'b1;
            st_nxt   = BK_FCHK;
          end else begin
            base_nxt = cmd.first;
            pos_nxt  = cmd.first;
            rvld_nxt = 1'b1;
            st_nxt   = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if ({1'b0, base_r} + {1'b0, c_r.req} > {1'b0, limit_n}) begin
          res_st_nxt = ST_NOFIT;
          st_nxt     = BK_DONE;
        end else if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else if (rdata != MARK_FREE) begin
          base_nxt = nxt_base;
          pos_nxt  = nxt_base;
          rvld_nxt = 1'b1;
        end else if (pos_adv == cand_end) begin
          pos_nxt = base_r;
          st_nxt  = BK_MARK;
        end else begin
          pos_nxt  = pos_adv;
          rvld_nxt = 1'b1;
        end
      end
      BK_MARK: begin
        pos_nxt = pos_adv;
        tot_nxt = tot_r + 17'd1;
        if (pos_adv == cand_end) begin
          res_st_nxt   = ST_OK;
          res_addr_nxt = region_base + (32'(base_r) << block_shift);
          st_nxt       = BK_DONE;
        end
      end
      BK_FCHK: begin
        if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else if (rdata != MARK_START) begin
          res_st_nxt = ST_BADFREE;
          st_nxt     = BK_DONE;
        end else begin
          if (tot_r != 17'd0) tot_nxt = tot_r - 17'd1;
          pos_nxt  = pos_adv;
          rvld_nxt = 1'b1;
          res_st_nxt = ST_OK;
          st_nxt   = (pos_adv == 17'(MAX_BLOCKS)) ? BK_DONE : BK_FWALK;
        end
      end
      BK_FWALK: begin
        if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else if (rdata == MARK_START || rdata == MARK_FREE) begin
          st_nxt = BK_DONE;
        end else begin
          if (tot_r != 17'd0) tot_nxt = tot_r - 17'd1;
          pos_nxt  = pos_adv;
          rvld_nxt = (pos_adv != 17'(MAX_BLOCKS));
          if (pos_adv == 17'(MAX_BLOCKS)) st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // outputs
  always_comb begin
    we        = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = MARK_FREE;
    raddr     = pos_nxt[AW-1:0];
    cmd_ready = 1'b0;
    case (st_r)
      BK_IDLE: begin
        cmd_ready = !clr_r;
        we        = clr_r;
      end
      BK_MARK: begin
        we = 1'b1;
        if (pos_r == base_r) wdata = MARK_START;
        else if (pos_adv == cand_end) wdata = MARK_END;
        else wdata = MARK_MIDDLE;
      end
      BK_FCHK: we = rvld_r && (rdata == MARK_START);
      BK_FWALK: we = rvld_r && (rdata == MARK_MIDDLE || rdata == MARK_END);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      pos_r  <= '0;
      tot_r  <= '0;
      clr_r  <= 1'b1;
      ov_r   <= 1'b0;
      rvld_r <= 1'b0;
      c_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      tot_r  <= tot_nxt;
      clr_r  <= clr_nxt;
      ov_r   <= ov_nxt;
      rvld_r <= rvld_nxt;
      if (cmd_valid && cmd_ready) c_r <= cmd;
    end
    base_r     <= base_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    if (st_r == BK_DONE && !ov_r) begin
      status          <= res_st_r;
      granted_address <= res_addr_r;
      used_count      <= tot_r[10:0];
      free_count      <= free_w[10:0];
    end
  end

  assign free_w    = (limit_n > tot_r) ? (limit_n - tot_r) : 17'd0;
  assign out_valid = ov_r;
  assign busy      = (st_r != BK_IDLE) || ov_r || clr_r || cmd_valid;

`ifndef SYNTH
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (st_r != BK_SCAN && st_r != BK_DONE))
    else $error("map written while searching");
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= 17'(MAX_BLOCKS))
    else $error("allocated total exceeds map");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(status))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire

>>> rtl/core/first_fit_block_allocator_core.sv
`default_nettype none
// first-fit block allocator over a 2-bit mark map held in a single-port-write ram.
// requests arrive on in_*, are decoded (block rounding, alignment offset, free block
// number) by a front end and queued two deep; a back end scans or walks the map one
// mark per cycle: an alloc probes candidate blocks and then marks the chosen run, and a
// free checks the start mark and then clears the released run. one result transaction
// per request on out_*, held in an output register. after reset a clearing pass writes
// every map entry free, during which the back end takes no request and the front end
// queues at most two. registers at 0x0 block_shift, 0x4 usable_blocks, 0x8 region_base.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // request_bytes[31:0], align_log2[36:32], release_address[68:37], zero fill
  input  wire logic [71:0]       in_tdata,
  // opcode
  input  wire logic              in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // granted_address[31:0], free_count[42:32], used_count[53:43], zero fill
  output logic [55:0]            out_tdata,
  // status
  output logic [1:0]             out_tuser,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [4:0]  block_shift_r;
  logic [10:0] usable_r;
  logic [31:0] base_r;
  logic [16:0] limit_n;
  logic        cmd_valid, cmd_ready, busy;
  cmd_t        cmd;
  logic [31:0] gaddr;
  logic [10:0] fcnt, ucnt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= 5'd12;
      usable_r      <= 11'd1024;
      base_r        <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        REG_BLOCK_SHIFT:   block_shift_r <= cfg_pwdata[4:0];
        REG_USABLE_BLOCKS: usable_r      <= cfg_pwdata[10:0];
        REG_REGION_BASE:   base_r        <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_BLOCK_SHIFT:   cfg_prdata = {27'd0, block_shift_r};
      REG_USABLE_BLOCKS: cfg_prdata = {21'd0, usable_r};
      REG_REGION_BASE:   cfg_prdata = base_r;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // effective block limit
  assign limit_n = ({6'd0, usable_r} < 17'(MAX_BLOCKS)) ? {6'd0, usable_r} : 17'(MAX_BLOCKS);

  ffba_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .op_free(in_tuser),
    .request_bytes(in_tdata[31:0]),
    .align_log2(in_tdata[36:32]),
    .release_address(in_tdata[68:37]),
    .block_shift(block_shift_r), .limit_n(limit_n), .region_base(base_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  ffba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .block_shift(block_shift_r), .limit_n(limit_n), .region_base(base_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .status(out_tuser), .granted_address(gaddr),
    .free_count(fcnt), .used_count(ucnt), .busy(busy)
  );

  assign out_tdata = {2'b00, ucnt, fcnt, gaddr};

`ifndef SYNTH
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && !busy) |=> !out_tvalid)
    else $error("result appeared after idle config write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy)
    else $error("result pending but block idle");
`endif
endmodule
`default_nettype wire
